FILE: rtl/core/xcfd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the XOR-checked frame deframer.
// ---------------------------------------------------------------------------
package xcfd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CMD    = 3'd1,
        PH_ADDR   = 3'd2,
        PH_LEN_H  = 3'd3,
        PH_LEN_L  = 3'd4,
        PH_DATA   = 3'd5,
        PH_CHECK  = 3'd6
    } phase_t;

    // Input item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Register reset values
    localparam logic [7:0]  HEADER_RESET  = 8'hAA;
    localparam logic [8:0]  MAX_LEN_RESET = 9'd256;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [8:0]  max_length;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  command;
        logic [7:0]  address;
        logic [15:0] frame_length;
        logic [1:0]  status;
    } result_t;

endpackage

FILE: rtl/core/xcfd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfd_if
// Valid/ready channel interfaces: received items, results, register writes.
// ---------------------------------------------------------------------------
interface xcfd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface xcfd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [7:0]  command;
    logic [7:0]  address;
    logic [15:0] frame_length;
    logic [1:0]  status;

    modport source (output valid, output kind, output payload_byte, output byte_index,
                    output command, output address, output frame_length,
                    output status, input ready);
    modport sink   (input valid, input kind, input payload_byte, input byte_index,
                    input command, input address, input frame_length,
                    input status, output ready);
endinterface

interface xcfd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [xcfd_pkg::CFG_IDX_W-1:0]  index;
    logic [xcfd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/xcfd_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfd_cfg_regs
// Configuration register file: header value, length limit, idle timeout.
// ---------------------------------------------------------------------------
module xcfd_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    xcfd_cfg_if.sink       cfg,
    output xcfd_pkg::cfg_t cfg_q
);

    logic [7:0]  header_value_reg,  header_value_next;
    logic [8:0]  max_length_reg,    max_length_next;
    logic [15:0] timeout_ticks_reg, timeout_ticks_next;

    assign cfg.ready = 1'b1;

    // Decode a register write transfer
    always_comb
    begin
        header_value_next  = header_value_reg;
        max_length_next    = max_length_reg;
        timeout_ticks_next = timeout_ticks_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                xcfd_pkg::CFG_HEADER_VALUE:  header_value_next  = cfg.data[7:0];
                xcfd_pkg::CFG_MAX_LENGTH:    max_length_next    = cfg.data[8:0];
                xcfd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_next = cfg.data;
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg  <= xcfd_pkg::HEADER_RESET;
            max_length_reg    <= xcfd_pkg::MAX_LEN_RESET;
            timeout_ticks_reg <= xcfd_pkg::TIMEOUT_RESET;
        end
        else
        begin
            header_value_reg  <= header_value_next;
            max_length_reg    <= max_length_next;
            timeout_ticks_reg <= timeout_ticks_next;
        end
    end

    assign cfg_q.header_value  = header_value_reg;
    assign cfg_q.max_length    = max_length_reg;
    assign cfg_q.timeout_ticks = timeout_ticks_reg;

endmodule

FILE: rtl/core/xcfd_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfd_parser
// Frame parse state machine: one input item per cycle while the result buffer has space, at most one result.
// ---------------------------------------------------------------------------
module xcfd_parser #(
    parameter int MAX_PAYLOAD_BYTES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    xcfd_in_if.sink           rx_in,
    input  xcfd_pkg::cfg_t    cfg_q,
    input  logic              res_space,
    output logic              res_valid,
    output xcfd_pkg::result_t res_data
);

    localparam int CountW = $clog2(MAX_PAYLOAD_BYTES + 1);

    xcfd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        command_reg,   command_next;
    logic [7:0]        address_reg,   address_next;
    logic [15:0]       length_reg,    length_next;
    logic [CountW-1:0] count_reg,     count_next;
    logic [7:0]        xor_reg,       xor_next;
    logic [15:0]       idle_reg,      idle_next;

    logic              accept;
    logic              in_frame;
    logic [15:0]       idle_inc;
    logic              timeout_hit;
    logic [15:0]       length_full;
    logic [15:0]       limit;
    logic              too_long;
    logic [CountW-1:0] count_inc;
    logic [15:0]       count_ext;
    logic [15:0]       count_inc_ext;

    assign rx_in.ready = res_space;
    assign accept      = rx_in.valid && res_space;

    // Shared decode
    assign in_frame      = (phase_reg inside {xcfd_pkg::PH_CMD, xcfd_pkg::PH_ADDR,
                                              xcfd_pkg::PH_LEN_H, xcfd_pkg::PH_LEN_L,
                                              xcfd_pkg::PH_DATA, xcfd_pkg::PH_CHECK});
    assign idle_inc      = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign timeout_hit   = idle_inc > cfg_q.timeout_ticks;
    assign length_full   = {length_reg[15:8], rx_in.rx_byte};
    assign limit         = (16'(cfg_q.max_length) > 16'(MAX_PAYLOAD_BYTES))
                           ? 16'(MAX_PAYLOAD_BYTES) : 16'(cfg_q.max_length);
    assign too_long      = length_full > limit;
    assign count_inc     = count_reg + CountW'(1);
    assign count_ext     = 16'(count_reg);
    assign count_inc_ext = 16'(count_inc);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (rx_in.action == xcfd_pkg::ACT_TICK)
            begin
                if (!in_frame)
                    phase_next = xcfd_pkg::PH_HEADER;
                else if (timeout_hit)
                    phase_next = xcfd_pkg::PH_HEADER;
            end
            else
            begin
                case (phase_reg)
                    xcfd_pkg::PH_CMD:   phase_next = xcfd_pkg::PH_ADDR;
                    xcfd_pkg::PH_ADDR:  phase_next = xcfd_pkg::PH_LEN_H;
                    xcfd_pkg::PH_LEN_H: phase_next = xcfd_pkg::PH_LEN_L;
                    xcfd_pkg::PH_LEN_L:
                    begin
                        if (too_long)
                            phase_next = xcfd_pkg::PH_HEADER;
                        else if (length_full == 16'd0)
                            phase_next = xcfd_pkg::PH_CHECK;
                        else
                            phase_next = xcfd_pkg::PH_DATA;
                    end
                    xcfd_pkg::PH_DATA:
                    begin
                        if (count_inc_ext >= length_reg)
                            phase_next = xcfd_pkg::PH_CHECK;
                    end
                    xcfd_pkg::PH_CHECK: phase_next = xcfd_pkg::PH_HEADER;
                    default:
                    begin
                        // waiting for header, also any stray code
                        if (rx_in.rx_byte == cfg_q.header_value)
                            phase_next = xcfd_pkg::PH_CMD;
                        else
                            phase_next = xcfd_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    // Datapath and result
    always_comb
    begin
        command_next = command_reg;
        address_next = address_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        idle_next    = idle_reg;
        res_valid    = 1'b0;
        res_data     = '0;
        res_data.command      = command_reg;
        res_data.address      = address_reg;
        res_data.frame_length = length_reg;
        if (accept)
        begin
            if (rx_in.action == xcfd_pkg::ACT_TICK)
            begin
                if (in_frame)
                begin
                    if (timeout_hit)
                    begin
                        idle_next       = 16'd0;
                        res_valid       = 1'b1;
                        res_data.kind   = xcfd_pkg::KIND_VERDICT;
                        res_data.status = xcfd_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            else
            begin
                idle_next = 16'd0;
                case (phase_reg)
                    xcfd_pkg::PH_CMD:
                    begin
                        command_next = rx_in.rx_byte;
                        xor_next     = xor_reg ^ rx_in.rx_byte;
                    end
                    xcfd_pkg::PH_ADDR:
                    begin
                        address_next = rx_in.rx_byte;
                        xor_next     = xor_reg ^ rx_in.rx_byte;
                    end
                    xcfd_pkg::PH_LEN_H:
                    begin
                        length_next = {rx_in.rx_byte, 8'h00};
                        xor_next    = xor_reg ^ rx_in.rx_byte;
                    end
                    xcfd_pkg::PH_LEN_L:
                    begin
                        length_next = length_full;
                        xor_next    = xor_reg ^ rx_in.rx_byte;
                        count_next  = '0;
                        if (too_long)
                        begin
                            res_valid             = 1'b1;
                            res_data.kind         = xcfd_pkg::KIND_VERDICT;
                            res_data.frame_length = length_full;
                            res_data.status       = xcfd_pkg::ST_TOO_LONG;
                        end
                    end
                    xcfd_pkg::PH_DATA:
                    begin
                        xor_next   = xor_reg ^ rx_in.rx_byte;
                        count_next = count_inc;
                        res_valid  = 1'b1;
                        res_data   = '0;
                        res_data.kind         = xcfd_pkg::KIND_PAYLOAD;
                        res_data.payload_byte = rx_in.rx_byte;
                        res_data.byte_index   = count_ext[7:0];
                    end
                    xcfd_pkg::PH_CHECK:
                    begin
                        res_valid       = 1'b1;
                        res_data.kind   = xcfd_pkg::KIND_VERDICT;
                        res_data.status = (rx_in.rx_byte == xor_reg)
                                          ? xcfd_pkg::ST_OK : xcfd_pkg::ST_MISMATCH;
                    end
                    default:
                    begin
                        // header match clears the frame context
                        if (rx_in.rx_byte == cfg_q.header_value)
                        begin
                            command_next = 8'd0;
                            address_next = 8'd0;
                            length_next  = 16'd0;
                            count_next   = '0;
                            xor_next     = 8'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= xcfd_pkg::PH_HEADER;
            command_reg <= 8'd0;
            address_reg <= 8'd0;
            length_reg  <= 16'd0;
            count_reg   <= '0;
            xor_reg     <= 8'd0;
            idle_reg    <= 16'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            address_reg <= address_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            idle_reg    <= idle_next;
        end
    end

    // Any verdict ends the frame
    a_verdict_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.kind == xcfd_pkg::KIND_VERDICT)
        |=> phase_reg == xcfd_pkg::PH_HEADER)
        else $error("parser did not return to header after a verdict");

    // Payload phase only with bytes still owed
    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == xcfd_pkg::PH_DATA |-> (length_reg != 16'd0 && count_ext < length_reg))
        else $error("payload count reached declared length in payload phase");

    // A received byte clears the idle timer
    a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx_in.action == xcfd_pkg::ACT_BYTE) |=> idle_reg == 16'd0)
        else $error("idle timer not cleared by received byte");

endmodule

FILE: rtl/core/xcfd_out_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfd_out_buf
// Two-entry result buffer: output register plus skid register.
// ---------------------------------------------------------------------------
module xcfd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  xcfd_pkg::result_t push_data,
    output logic              space,
    xcfd_out_if.source        res_out
);

    logic              out_valid_reg,  out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    xcfd_pkg::result_t out_data_reg,   out_data_next;
    xcfd_pkg::result_t skid_data_reg,  skid_data_next;
    logic              pop;

    assign pop   = out_valid_reg && res_out.ready;
    assign space = !skid_valid_reg;

    // Fill and drain; a push only arrives while the skid entry is empty
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.kind         = out_data_reg.kind;
    assign res_out.payload_byte = out_data_reg.payload_byte;
    assign res_out.byte_index   = out_data_reg.byte_index;
    assign res_out.command      = out_data_reg.command;
    assign res_out.address      = out_data_reg.address;
    assign res_out.frame_length = out_data_reg.frame_length;
    assign res_out.status       = out_data_reg.status;

    // Skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with output register empty");

endmodule

FILE: rtl/core/xor_checked_frame_deframer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xor_checked_frame_deframer_top
// Length-prefixed frame parser with XOR check byte and idle timeout.
// ---------------------------------------------------------------------------
// Takes one input item (received byte or time tick) per clock cycle unless
// the output buffer is full. Frames are header, command, address, 16-bit
// big-endian length, payload and an XOR check over everything after the
// header. Each payload byte comes out as a payload result with its index;
// the check byte, an oversize length or an idle timeout gives a verdict
// result. The whole parse step is combinational between the parser state
// registers and the output register, where results are registered. A
// two-entry output buffer lets input continue while one result waits; input
// stalls only when both entries are full. Configuration writes take effect
// on the next cycle and should be made while no frame is in progress.
// ---------------------------------------------------------------------------
module xor_checked_frame_deframer_top #(
    parameter int MAX_PAYLOAD_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    xcfd_in_if.sink     rx_in,
    xcfd_out_if.source  res_out,
    xcfd_cfg_if.sink    cfg
);

    xcfd_pkg::cfg_t    cfg_q;
    xcfd_pkg::result_t res_data;
    logic              res_valid;
    logic              res_space;

    // Register file
    xcfd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Parse logic
    xcfd_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_in     (rx_in),
        .cfg_q     (cfg_q),
        .res_space (res_space),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Result buffer
    xcfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .space     (res_space),
        .res_out   (res_out)
    );

endmodule
